FILE: rtl/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg: shared types and constants of the modular exponentiation block
// Holds the default word size, the configuration register indexes and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package mexp_pkg;

	// Default machine word; values are one bit narrower than this.
	localparam int WORD_BITS_DEF = 32;

	// Configuration register indexes.
	localparam int CFG_IDX_BITS = 1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_EXPONENT = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_MODULUS  = 1'b1;

	// Operand selection for the modular multiplier.
	typedef enum logic [1:0] {
		OP_REDUCE = 2'd0,   // base mod modulus, computed as 1 * base
		OP_SQUARE = 2'd1,   // acc * acc
		OP_MULT   = 2'd2    // acc * base
	} mexp_op_t;

	// Source of the value placed in the output register.
	typedef enum logic [1:0] {
		SRC_ACC  = 2'd0,
		SRC_ONE  = 2'd1,
		SRC_ZERO = 2'd2
	} mexp_src_t;

	typedef struct packed {
		logic      load;       // capture the base and start a new exponent scan
		logic      mul_start;  // launch one modular multiply
		mexp_op_t  op;         // operands of that multiply
		logic      bit_next;   // advance to the next exponent bit
		logic      res_load;   // write the output register
		mexp_src_t res_src;    // what to write there
	} mexp_cmd_t;

	typedef struct packed {
		logic mul_done;   // the multiply launched last has finished
		logic exp_bit;    // exponent bit under scan
		logic last_bit;   // that bit is the least significant one
		logic exp_zero;   // configured exponent is zero
		logic mod_zero;   // configured modulus is zero
	} mexp_sts_t;

endpackage

FILE: rtl/mexp_mulmod.sv
// ----------------------------------------------------------------------------
// mexp_mulmod: bit-serial interleaved modular multiplier
// Computes (a * b) mod m one multiplier bit per cycle, most significant first.
// ----------------------------------------------------------------------------
module mexp_mulmod #(
	parameter int WORD_BITS = mexp_pkg::WORD_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [WORD_BITS-2:0] a,
	input  logic [WORD_BITS-2:0] b,
	input  logic [WORD_BITS-2:0] m,
	output logic                 done,
	output logic [WORD_BITS-2:0] result
);
	localparam int VAL_BITS = WORD_BITS - 1;
	localparam int CNT_W    = $clog2(VAL_BITS);

	logic [VAL_BITS-1:0] acc_q;
	logic [VAL_BITS-1:0] a_q;
	logic [VAL_BITS-1:0] b_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                busy_q;
	logic                done_q;

	logic [VAL_BITS:0] m_ext;
	logic [VAL_BITS:0] dbl;
	logic [VAL_BITS:0] red1;
	logic [VAL_BITS:0] sum;
	logic [VAL_BITS:0] red2;

	// Each step keeps the partial value below m: double and reduce, then
	// add the multiplicand when the multiplier bit is set and reduce again.
	always_comb begin
		m_ext = {1'b0, m};
		dbl   = {acc_q, 1'b0};
		red1  = (dbl >= m_ext) ? (dbl - m_ext) : dbl;
		sum   = red1 + (b_q[VAL_BITS-1] ? {1'b0, a_q} : '0);
		red2  = (sum >= m_ext) ? (sum - m_ext) : sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && (cnt_q == '0)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= a;
			b_q   <= b;
			cnt_q <= CNT_W'(VAL_BITS - 1);
		end else if (busy_q) begin
			acc_q <= red2[VAL_BITS-1:0];
			b_q   <= {b_q[VAL_BITS-2:0], 1'b0};
			cnt_q <= cnt_q - 1'b1;
		end
	end

	assign done   = done_q;
	assign result = acc_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("multiply started while one is in progress");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("multiply done held for more than one cycle");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done_q) |-> $past(busy_q))
		else $error("multiply done without a multiply in progress");

endmodule

FILE: rtl/mexp_dp.sv
// ----------------------------------------------------------------------------
// mexp_dp: datapath of the modular exponentiation block
// Configuration registers, base and accumulator registers, exponent scan
// and the output register around one shared modular multiplier.
// ----------------------------------------------------------------------------
module mexp_dp #(
	parameter int WORD_BITS = mexp_pkg::WORD_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	input  logic [mexp_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [WORD_BITS-2:0]              cfg_data,
	input  logic [WORD_BITS-2:0]              base,
	input  mexp_pkg::mexp_cmd_t               cmd,
	output mexp_pkg::mexp_sts_t               sts,
	output logic [WORD_BITS-2:0]              power_mod
);
	import mexp_pkg::*;

	localparam int VAL_BITS = WORD_BITS - 1;
	localparam int KCNT_W   = $clog2(VAL_BITS);

	logic [VAL_BITS-1:0] exp_cfg_q;
	logic [VAL_BITS-1:0] mod_cfg_q;
	logic [VAL_BITS-1:0] base_q;
	logic [VAL_BITS-1:0] pacc_q;
	logic [VAL_BITS-1:0] exp_q;
	logic [KCNT_W-1:0]   kcnt_q;
	logic [VAL_BITS-1:0] res_q;
	mexp_op_t            op_q;
	logic                start_q;

	logic [VAL_BITS-1:0] mul_a;
	logic [VAL_BITS-1:0] mul_b;
	logic [VAL_BITS-1:0] mul_res;
	logic                mul_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_cfg_q <= VAL_BITS'(1);
			mod_cfg_q <= VAL_BITS'(1);
			start_q   <= 1'b0;
		end else begin
			start_q <= cmd.mul_start;
			if (cfg_valid) begin
				case (cfg_index)
					CFG_EXPONENT: exp_cfg_q <= cfg_data;
					CFG_MODULUS:  mod_cfg_q <= cfg_data;
					default:      ;
				endcase
			end
		end
	end

	// The multiply is launched in the cycle after the command so that its
	// operands come from registers already updated by the previous result.
	always_comb begin
		case (op_q)
			OP_REDUCE: begin
				mul_a = VAL_BITS'(1);
				mul_b = base_q;
			end
			OP_SQUARE: begin
				mul_a = pacc_q;
				mul_b = pacc_q;
			end
			OP_MULT: begin
				mul_a = pacc_q;
				mul_b = base_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	mexp_mulmod #(
		.WORD_BITS (WORD_BITS)
	) u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.a      (mul_a),
		.b      (mul_b),
		.m      (mod_cfg_q),
		.done   (mul_done),
		.result (mul_res)
	);

	always_ff @(posedge clk) begin
		if (cmd.mul_start) begin
			op_q <= cmd.op;
		end
		if (cmd.load) begin
			base_q <= base;
			exp_q  <= exp_cfg_q;
			kcnt_q <= KCNT_W'(VAL_BITS - 1);
			pacc_q <= (mod_cfg_q == VAL_BITS'(1)) ? '0 : VAL_BITS'(1);
		end else begin
			if (cmd.bit_next) begin
				exp_q  <= {exp_q[VAL_BITS-2:0], 1'b0};
				kcnt_q <= kcnt_q - 1'b1;
			end
			if (mul_done) begin
				if (op_q == OP_REDUCE) begin
					base_q <= mul_res;
				end else begin
					pacc_q <= mul_res;
				end
			end
		end
		if (cmd.res_load) begin
			case (cmd.res_src)
				SRC_ACC:  res_q <= pacc_q;
				SRC_ONE:  res_q <= VAL_BITS'(1);
				SRC_ZERO: res_q <= '0;
				default:  res_q <= '0;
			endcase
		end
	end

	always_comb begin
		sts.mul_done = mul_done;
		sts.exp_bit  = exp_q[VAL_BITS-1];
		sts.last_bit = (kcnt_q == '0);
		sts.exp_zero = (exp_cfg_q == '0);
		sts.mod_zero = (mod_cfg_q == '0);
	end

	assign power_mod = res_q;

endmodule

FILE: rtl/mexp_ctrl.sv
// ----------------------------------------------------------------------------
// mexp_ctrl: sequencer of the modular exponentiation block
// Reduces the base, walks the exponent bits issuing square and multiply
// steps, and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module mexp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  mexp_pkg::mexp_sts_t sts,
	output mexp_pkg::mexp_cmd_t cmd
);
	import mexp_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_REDUCE = 5'b00010,
		S_SQUARE = 5'b00100,
		S_MULT   = 5'b01000,
		S_FINISH = 5'b10000
	} mexp_state_t;

	mexp_state_t state_q;
	mexp_state_t state_n;
	mexp_src_t   src_q;
	mexp_src_t   src_n;
	logic        out_valid_q;

	always_comb begin
		cmd     = '0;
		state_n = state_q;
		src_n   = src_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					if (sts.exp_zero) begin
						src_n   = SRC_ONE;
						state_n = S_FINISH;
					end else if (sts.mod_zero) begin
						src_n   = SRC_ZERO;
						state_n = S_FINISH;
					end else begin
						src_n         = SRC_ACC;
						cmd.mul_start = 1'b1;
						cmd.op        = OP_REDUCE;
						state_n       = S_REDUCE;
					end
				end
			end
			S_REDUCE: begin
				if (sts.mul_done) begin
					cmd.mul_start = 1'b1;
					cmd.op        = OP_SQUARE;
					state_n       = S_SQUARE;
				end
			end
			S_SQUARE: begin
				if (sts.mul_done) begin
					if (sts.exp_bit) begin
						cmd.mul_start = 1'b1;
						cmd.op        = OP_MULT;
						state_n       = S_MULT;
					end else if (sts.last_bit) begin
						state_n = S_FINISH;
					end else begin
						cmd.bit_next  = 1'b1;
						cmd.mul_start = 1'b1;
						cmd.op        = OP_SQUARE;
					end
				end
			end
			S_MULT: begin
				if (sts.mul_done) begin
					if (sts.last_bit) begin
						state_n = S_FINISH;
					end else begin
						cmd.bit_next  = 1'b1;
						cmd.mul_start = 1'b1;
						cmd.op        = OP_SQUARE;
						state_n       = S_SQUARE;
					end
				end
			end
			S_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					cmd.res_load = 1'b1;
					cmd.res_src  = src_q;
					state_n      = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			src_q       <= SRC_ACC;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			src_q   <= src_n;
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> (!out_valid_q || !out_stall))
		else $error("output register overwritten while its item is stalled");

	a_done_in_mul: assert property (@(posedge clk) disable iff (!arst_n)
		sts.mul_done |-> (state_q == S_REDUCE || state_q == S_SQUARE ||
			state_q == S_MULT))
		else $error("multiply finished outside a multiply state");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q != S_IDLE))
		else $error("accepted item did not start work");

endmodule

FILE: rtl/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// modular_exponentiation: base ** exponent mod modulus, square-and-multiply
// Top level joining the sequencer and the datapath.
// ----------------------------------------------------------------------------
// Usage:
// An item on the input channel (in_valid, in_stall, base) is raised to the
// configured exponent modulo the configured modulus; the result leaves on
// the output channel (out_valid, out_stall, power_mod). An item is moved on
// a rising edge where valid is high and stall is low.
// Registers are written through cfg_valid/cfg_ready/cfg_index/cfg_data,
// index 0 the exponent and index 1 the modulus; cfg_ready is always high.
// Write them only while no item is in flight.
// Items are processed one at a time. With W = WORD_BITS - 1, each modular
// multiply is done by the shared bit-serial multiplier, which sets the
// rate. An item needs one reduction of the base, W squarings and one
// multiply per set exponent bit. A zero exponent or modulus answers
// without any multiply.
// A new item is taken as soon as the previous one has reached the output
// register, even if the receiver still stalls it; the next result then
// waits until that register is free.
// Reset sets exponent and modulus to 1 and empties the block.
// ----------------------------------------------------------------------------
module modular_exponentiation #(
	parameter int WORD_BITS = mexp_pkg::WORD_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [WORD_BITS-2:0]              base,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [WORD_BITS-2:0]              power_mod,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [mexp_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [WORD_BITS-2:0]              cfg_data
);
	import mexp_pkg::*;

	// Commands from the sequencer and status back from the datapath.
	mexp_cmd_t cmd;
	mexp_sts_t sts;

	// Configuration writes go straight into registers and are never held off.
	assign cfg_ready = 1'b1;

	mexp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	mexp_dp #(
		.WORD_BITS (WORD_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.base      (base),
		.cmd       (cmd),
		.sts       (sts),
		.power_mod (power_mod)
	);

endmodule
